### src/api_frame_receiver_defines.svh
// Assertion macros for the API frame receiver.
// Included by api_frame_receiver, the module that carries the concurrent assertions; no other dependencies.
`ifndef API_FRAME_RECEIVER_DEFINES_SVH
`define API_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("api_frame_receiver: implication check failed");

// Next-cycle implication, checked outside reset.
`define AFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("api_frame_receiver: next-cycle check failed");

`endif

### src/afr_pkg.sv
// Shared types and constants for the API frame receiver.
// Used by the parser, the result register and the top level of the block; depends on nothing.
package afr_pkg;

  localparam logic [7:0]  FRAME_DELIM    = 8'h7E;
  localparam logic [7:0]  SMS_RX_TYPE    = 8'h9F;
  localparam logic [7:0]  SUM_COMPLEMENT = 8'hFF;
  localparam logic [15:0] BUF_SIZE_RESET = 16'd256;
  localparam int          POS_W          = 17;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_BAD      = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic        is_sms_rx;
    logic [15:0] frame_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } step_t;

endpackage

### src/afr_in_stage.sv
// Input register for received bytes.
// Depends on nothing; holds one byte and its valid bit.
module afr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
    end
  end

endmodule

### src/afr_parser.sv
// Frame parser: frame state registers and the per-byte next-state logic.
// Depends on afr_pkg for constants and the step_t result type.
module afr_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_en,
  input  logic [7:0]     byte_in,
  input  logic [15:0]    buffer_size,
  output afr_pkg::step_t step
);

  logic                      in_frame, in_frame_next;
  logic [afr_pkg::POS_W-1:0] position, position_next;
  logic [15:0]               length_field, length_field_next;
  logic [7:0]                running_sum, running_sum_next;
  logic [7:0]                first_data_byte, first_data_byte_next;
  logic [afr_pkg::POS_W-1:0] pos_inc;
  logic [afr_pkg::POS_W-1:0] data_end;
  logic                      good;
  logic [7:0]                ft;

  assign pos_inc  = position + afr_pkg::POS_W'(1);
  assign data_end = {1'b0, length_field} + afr_pkg::POS_W'(3);
  assign good     = ((afr_pkg::SUM_COMPLEMENT - running_sum) == byte_in);
  assign ft       = (length_field == 16'd0) ? 8'd0 : first_data_byte;

  always_comb begin
    in_frame_next        = in_frame;
    position_next        = position;
    length_field_next    = length_field;
    running_sum_next     = running_sum;
    first_data_byte_next = first_data_byte;
    step                 = '0;
    if (step_en) begin
      if (byte_in == afr_pkg::FRAME_DELIM) begin
        in_frame_next        = 1'b1;
        position_next        = '0;
        length_field_next    = '0;
        running_sum_next     = '0;
        first_data_byte_next = '0;
      end else if (in_frame) begin
        if (pos_inc > {1'b0, buffer_size}) begin
          in_frame_next           = 1'b0;
          step.valid              = 1'b1;
          step.res.status         = afr_pkg::STATUS_OVERFLOW;
          step.res.frame_length   = length_field;
        end else begin
          position_next = pos_inc;
          if (pos_inc == afr_pkg::POS_W'(1)) begin
            length_field_next = {byte_in, 8'h00};
          end else if (pos_inc == afr_pkg::POS_W'(2)) begin
            length_field_next = {length_field[15:8], byte_in};
          end else if (pos_inc < data_end) begin
            if (pos_inc == afr_pkg::POS_W'(3)) begin
              first_data_byte_next = byte_in;
            end
            running_sum_next = running_sum + byte_in;
          end else begin
            in_frame_next         = 1'b0;
            step.valid            = 1'b1;
            step.res.status       = good ? afr_pkg::STATUS_GOOD : afr_pkg::STATUS_BAD;
            step.res.frame_type   = ft;
            step.res.is_sms_rx    = good && (length_field != 16'd0)
                                    && (ft == afr_pkg::SMS_RX_TYPE);
            step.res.frame_length = length_field;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      position        <= '0;
      length_field    <= '0;
      running_sum     <= '0;
      first_data_byte <= '0;
    end else begin
      in_frame        <= in_frame_next;
      position        <= position_next;
      length_field    <= length_field_next;
      running_sum     <= running_sum_next;
      first_data_byte <= first_data_byte_next;
    end
  end

endmodule

### src/afr_out_stage.sv
// Result register that holds one frame report until it is taken.
// Depends on afr_pkg for the step_t and result_t types.
module afr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  afr_pkg::step_t   step,
  input  logic             out_ready,
  output logic             advance,
  output logic             out_valid,
  output afr_pkg::result_t res_q
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.valid) begin
      res_q <= step.res;
    end
  end

endmodule

### src/api_frame_receiver.sv
// API frame receiver: checks framing and checksum of a received modem byte stream.
// Depends on afr_pkg, api_frame_receiver_defines.svh, afr_in_stage, afr_parser and
// afr_out_stage.
//
// The block accepts one byte per clock cycle unless its input stalls, and reports each
// finished frame once: checksum good or bad, frame type, SMS-received flag and length, or
// an overflow when a frame runs past buffer_size byte positions. A byte accepted at a clock
// edge waits in the input register and is parsed from there; its report is loaded into the
// result register at an edge on which that register can advance, and stays on the outputs
// until it is taken. A report is made for the checksum byte or the overflowing byte.
// While a report waits to be taken, one more byte can enter the input register; after
// that the input stalls until out_ready rises, whether or not the waiting byte ends a
// frame. buffer_size is written through cfg_wr_en and cfg_wr_data and resets to 256.
`include "api_frame_receiver_defines.svh"

module api_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [7:0]  data_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [1:0]  status,
  output logic [7:0]  frame_type,
  output logic        is_sms_rx,
  output logic [15:0] frame_length,
  output logic        out_valid,
  input  logic        out_ready
);

  logic [15:0]      buffer_size;
  logic             advance;
  logic             byte_valid;
  logic [7:0]       byte_q;
  afr_pkg::step_t   step;
  afr_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= afr_pkg::BUF_SIZE_RESET;
    end else if (cfg_wr_en) begin
      buffer_size <= cfg_wr_data;
    end
  end

  afr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  afr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step_en     (byte_valid && advance),
    .byte_in     (byte_q),
    .buffer_size (buffer_size),
    .step        (step)
  );

  afr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .out_ready (out_ready),
    .advance   (advance),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign status       = res_q.status;
  assign frame_type   = res_q.frame_type;
  assign is_sms_rx    = res_q.is_sms_rx;
  assign frame_length = res_q.frame_length;

  `AFR_ASSERT_IMPLY(a_overflow_fields, clk, rst,
    out_valid && (status == afr_pkg::STATUS_OVERFLOW), (frame_type == 8'd0) && !is_sms_rx)
  `AFR_ASSERT_IMPLY(a_sms_needs_good, clk, rst, out_valid && is_sms_rx,
    (status == afr_pkg::STATUS_GOOD) && (frame_type == afr_pkg::SMS_RX_TYPE))
  `AFR_ASSERT_IMPLY(a_status_code, clk, rst, out_valid,
    (status == afr_pkg::STATUS_GOOD) || (status == afr_pkg::STATUS_BAD)
    || (status == afr_pkg::STATUS_OVERFLOW))
  `AFR_ASSERT_IMPLY(a_stall_only_when_full, clk, rst, !in_ready,
    byte_valid && out_valid && !out_ready)
  `AFR_ASSERT_NEXT(a_report_loads, clk, rst, advance && step.valid, out_valid)

endmodule

### test/afr_checker.sv
// Checker for the API frame receiver: watches the byte and report channels,
// predicts each frame report and compares it field by field.
// Depends on afr_pkg for the report type, status codes and framing constants.
`timescale 1ns / 100ps

module afr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [7:0]  data_byte,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  status,
  input  logic [7:0]  frame_type,
  input  logic        is_sms_rx,
  input  logic [15:0] frame_length,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          pending,
  output int          fail_count
);

  logic [15:0]               buf_limit;
  logic                      open_frame;
  logic [afr_pkg::POS_W-1:0] byte_pos;
  logic [15:0]               hdr_len;
  logic [7:0]                data_sum;
  logic [7:0]                type_byte;
  afr_pkg::result_t          reports_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("afr_checker: %s mismatch at %0t: got %0h, expected %0h", what, $time, got, want);
    fail_count++;
  endtask

  // Advances the frame parser by one byte and tells whether it closes a frame.
  task parse_byte(input logic [7:0] b, output bit done, output afr_pkg::result_t rep);
    logic [afr_pkg::POS_W-1:0] nxt;
    logic                      good;
    done = 1'b0;
    rep = '0;
    if (b == afr_pkg::FRAME_DELIM) begin
      open_frame = 1'b1;
      byte_pos = '0;
      hdr_len = '0;
      data_sum = '0;
      type_byte = '0;
    end else if (open_frame) begin
      nxt = byte_pos + 1'b1;
      if (nxt > {1'b0, buf_limit}) begin
        open_frame = 1'b0;
        done = 1'b1;
        rep.status = afr_pkg::STATUS_OVERFLOW;
        rep.frame_length = hdr_len;
      end else begin
        byte_pos = nxt;
        if (nxt == 1) begin
          hdr_len = {b, 8'h00};
        end else if (nxt == 2) begin
          hdr_len[7:0] = b;
        end else if (nxt < {1'b0, hdr_len} + 17'd3) begin
          if (nxt == 3) type_byte = b;
          data_sum = data_sum + b;
        end else begin
          good = (8'(afr_pkg::SUM_COMPLEMENT - data_sum) == b);
          open_frame = 1'b0;
          done = 1'b1;
          rep.status = good ? afr_pkg::STATUS_GOOD : afr_pkg::STATUS_BAD;
          rep.frame_type = (hdr_len == 0) ? 8'h00 : type_byte;
          rep.is_sms_rx = good && (hdr_len != 0) && (type_byte == afr_pkg::SMS_RX_TYPE);
          rep.frame_length = hdr_len;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    bit               done;
    afr_pkg::result_t rep;
    afr_pkg::result_t want;
    if (rst) begin
      buf_limit = afr_pkg::BUF_SIZE_RESET;
      open_frame = 1'b0;
      byte_pos = '0;
      hdr_len = '0;
      data_sum = '0;
      type_byte = '0;
      reports_due.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) buf_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          report("unexpected report, length", frame_length, '0);
        end else begin
          want = reports_due.pop_front();
          if (status != want.status) report("status", status, want.status);
          if (frame_type != want.frame_type) report("frame_type", frame_type, want.frame_type);
          if (is_sms_rx != want.is_sms_rx) report("is_sms_rx", is_sms_rx, want.is_sms_rx);
          if (frame_length != want.frame_length)
            report("frame_length", frame_length, want.frame_length);
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(data_byte, done, rep);
        if (done) reports_due.push_back(rep);
      end
      pending <= reports_due.size();
    end
  end

endmodule

### test/api_frame_receiver_tb.sv
// Testbench top for the API frame receiver: drives the byte stream, the buffer size
// register and the report handshake, and gives the verdict.
// Depends on afr_pkg, the block api_frame_receiver and the checker afr_checker.
`timescale 1ns / 100ps

module api_frame_receiver_tb;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 190;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic [7:0]  data_byte = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic        is_sms_rx;
  logic [15:0] frame_length;
  logic        out_valid;
  logic        out_ready = 1'b0;

  int          pending;
  int          fail_count;
  int          cycle_count = 0;
  int          items = 0;
  int          burst_left = 0;
  logic [15:0] bufsz_now = afr_pkg::BUF_SIZE_RESET;
  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int          mode_left = 0;
  int          pulse_cnt = 0;

  api_frame_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .data_byte    (data_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .status       (status),
    .frame_type   (frame_type),
    .is_sms_rx    (is_sms_rx),
    .frame_length (frame_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  afr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .data_byte    (data_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .status       (status),
    .frame_type   (frame_type),
    .is_sms_rx    (is_sms_rx),
    .frame_length (frame_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The report side stalls on its own pattern, with one long hold-off on request.
  always @(negedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (rst) begin
      nxt = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 120);
      end
      mode_left--;
      pulse_cnt++;
      unique case (rx_mode)
        RX_FREE:   nxt = 1'b1;
        RX_COIN:   nxt = $urandom_range(0, 1);
        RX_SPARSE: nxt = ($urandom_range(0, 3) == 0);
        RX_PULSE:  nxt = (pulse_cnt % 3 == 0);
      endcase
    end
    out_ready <= nxt;
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    v = $urandom;
    if (v == afr_pkg::FRAME_DELIM) v = v ^ 8'h01;
    return v;
  endfunction

  function automatic int frame_len();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 12);
    if (r < 8) return $urandom_range(0, 60);
    if (bufsz_now > 600) return $urandom_range(0, 255);
    v = int'(bufsz_now) - 3 + $urandom_range(0, 4) - 2;
    return (v < 0) ? 0 : v;
  endfunction

  // Entered and left at a falling edge; the sender may idle between bursts.
  task send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    data_byte <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Data bytes beyond the buffer are not sent, since the frame overflows before them.
  task automatic send_frame(input int len, input bit corrupt, input bit sms);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] ck;
    int         n_data;
    sum = '0;
    n_data = (len > int'(bufsz_now)) ? int'(bufsz_now) : len;
    send_byte(afr_pkg::FRAME_DELIM);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < n_data; i++) begin
      b = plain_byte();
      if (i == 0 && (sms || $urandom_range(0, 7) == 0)) b = afr_pkg::SMS_RX_TYPE;
      sum = sum + b;
      send_byte(b);
    end
    items += n_data + 3;
    if (n_data == len) begin
      ck = afr_pkg::SUM_COMPLEMENT - sum;
      if (corrupt) ck = ck ^ 8'($urandom_range(1, 255));
      send_byte(ck);
      items++;
    end
  endtask

  task automatic send_partial();
    int n;
    n = $urandom_range(0, 5);
    send_byte(afr_pkg::FRAME_DELIM);
    repeat (n) send_byte(plain_byte());
    items += n + 1;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(8'($urandom));
    items += n;
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task set_buffer(input logic [15:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    bufsz_now = v;
  endtask

  task automatic random_phase(input int budget);
    int start;
    int r;
    start = items;
    while (items - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_frame(frame_len(), $urandom_range(0, 3) == 0, 1'b0);
      end else if (r < 72) begin
        send_partial();
      end else if (r < 85) begin
        if (bufsz_now <= 600) send_frame($urandom_range(0, 65535), 1'b0, 1'b0);
        else send_frame(frame_len(), 1'b0, 1'b0);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 1'b0, 1'b0);
    send_frame(0, 1'b1, 1'b0);
    send_frame(3, 1'b0, 1'b1);
    send_frame(2, 1'b1, 1'b1);
    send_byte(afr_pkg::FRAME_DELIM);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(afr_pkg::SMS_RX_TYPE);
    send_frame(1, 1'b0, 1'b0);
    send_byte(8'h55);
    send_byte(8'hAA);

    hold_req <= 1'b1;
    repeat (12) send_frame(0, 1'b0, 1'b0);
    random_phase(PHASE_ITEMS);

    set_buffer(16'd4);
    send_frame(16'hFFFF, 1'b0, 1'b0);
    send_frame(1, 1'b0, 1'b1);
    send_frame(2, 1'b0, 1'b0);
    random_phase(PHASE_ITEMS);

    set_buffer(16'd0);
    random_phase(PHASE_ITEMS / 2);
    set_buffer(16'd1);
    random_phase(PHASE_ITEMS / 2);
    set_buffer(16'd3);
    random_phase(PHASE_ITEMS);
    set_buffer(16'd17);
    random_phase(PHASE_ITEMS);
    set_buffer(16'($urandom_range(5, 64)));
    random_phase(PHASE_ITEMS);
    set_buffer(16'hFFFF);
    random_phase(PHASE_ITEMS);
    set_buffer(16'($urandom_range(100, 600)));
    random_phase(PHASE_ITEMS);
    set_buffer(afr_pkg::BUF_SIZE_RESET);
    random_phase(PHASE_ITEMS);

    wait_idle();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
